// ----- design/adrc_pkg.sv -----
// ----------------------------------------------------------------------------
// adrc_pkg
// types, register codes and control store for the one-axis adrc regulator
// ----------------------------------------------------------------------------
`default_nettype none

package adrc_pkg;

   typedef logic signed [39:0] data_type;
   typedef logic [38:0]        gain_type;
   typedef logic [2:0]         csr_index_type;
   typedef logic [4:0]         step_type;

   // register indexes
   localparam csr_index_type REG_TRACK_GAIN     = 3'd0;
   localparam csr_index_type REG_OBSERVER_GAIN1 = 3'd1;
   localparam csr_index_type REG_OBSERVER_GAIN2 = 3'd2;
   localparam csr_index_type REG_PLANT_GAIN     = 3'd3;
   localparam csr_index_type REG_INV_PLANT_GAIN = 3'd4;
   localparam csr_index_type REG_DRIVE_LIMIT    = 3'd5;

   localparam gain_type TRACK_GAIN_RESET     = 39'd83886080;
   localparam gain_type OBSERVER_GAIN1_RESET = 39'd671088640;
   localparam gain_type OBSERVER_GAIN2_RESET = 39'd6710886400;
   localparam gain_type PLANT_GAIN_RESET     = 39'd4194304;
   localparam gain_type INV_PLANT_GAIN_RESET = 39'd67108864;
   localparam gain_type DRIVE_LIMIT_RESET    = 39'd25165824;

   // datapath operations
   localparam logic [3:0] OP_NOP   = 4'd0;
   localparam logic [3:0] OP_SEED  = 4'd1;
   localparam logic [3:0] OP_ADD   = 4'd2;
   localparam logic [3:0] OP_SUB   = 4'd3;
   localparam logic [3:0] OP_MUL   = 4'd4;
   localparam logic [3:0] OP_CLAMP = 4'd5;
   localparam logic [3:0] OP_CLEAR = 4'd6;
   localparam logic [3:0] OP_ZERO  = 4'd7;
   localparam logic [3:0] OP_DONE  = 4'd8;

   // jump conditions
   localparam logic [2:0] JC_NONE   = 3'd0;
   localparam logic [2:0] JC_CLEAR  = 3'd1;
   localparam logic [2:0] JC_BADDT  = 3'd2;
   localparam logic [2:0] JC_PRIMED = 3'd3;
   localparam logic [2:0] JC_ALWAYS = 3'd4;

   // operand sources
   localparam logic [3:0] SRC_SP   = 4'd0;
   localparam logic [3:0] SRC_MEAS = 4'd1;
   localparam logic [3:0] SRC_DT   = 4'd2;
   localparam logic [3:0] SRC_KP   = 4'd3;
   localparam logic [3:0] SRC_B1   = 4'd4;
   localparam logic [3:0] SRC_B2   = 4'd5;
   localparam logic [3:0] SRC_B0   = 4'd6;
   localparam logic [3:0] SRC_INV  = 4'd7;
   localparam logic [3:0] SRC_Z1   = 4'd8;
   localparam logic [3:0] SRC_Z2   = 4'd9;
   localparam logic [3:0] SRC_U    = 4'd10;
   localparam logic [3:0] SRC_ERR  = 4'd11;
   localparam logic [3:0] SRC_T    = 4'd12;
   localparam logic [3:0] SRC_D    = 4'd13;

   // destinations
   localparam logic [2:0] DST_NONE = 3'd0;
   localparam logic [2:0] DST_T    = 3'd1;
   localparam logic [2:0] DST_U    = 3'd2;
   localparam logic [2:0] DST_ERR  = 3'd3;
   localparam logic [2:0] DST_D    = 3'd4;
   localparam logic [2:0] DST_Z1   = 3'd5;
   localparam logic [2:0] DST_Z2   = 3'd6;

   // program entry points
   localparam step_type STEP_CALC  = 5'd4;
   localparam step_type STEP_CLEAR = 5'd20;
   localparam step_type STEP_ZERO  = 5'd21;
   localparam step_type STEP_DONE  = 5'd22;

   typedef struct packed {
      logic [3:0] op;
      logic [2:0] cond;
      step_type   target;
      logic [3:0] src_a;
      logic [3:0] src_b;
      logic [2:0] dst;
   } ucode_type;

   function automatic ucode_type uw(input logic [3:0] op, input logic [2:0] cond,
                                    input step_type target, input logic [3:0] src_a,
                                    input logic [3:0] src_b, input logic [2:0] dst);
      ucode_type w;
      w.op     = op;
      w.cond   = cond;
      w.target = target;
      w.src_a  = src_a;
      w.src_b  = src_b;
      w.dst    = dst;
      return w;
   endfunction

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      case (step)
         5'd0:    w = uw(OP_NOP,   JC_CLEAR,  STEP_CLEAR, SRC_T,    SRC_T,   DST_NONE);
         5'd1:    w = uw(OP_NOP,   JC_BADDT,  STEP_ZERO,  SRC_T,    SRC_T,   DST_NONE);
         5'd2:    w = uw(OP_NOP,   JC_PRIMED, STEP_CALC,  SRC_T,    SRC_T,   DST_NONE);
         5'd3:    w = uw(OP_SEED,  JC_NONE,   STEP_CALC,  SRC_T,    SRC_T,   DST_NONE);
         // drive = ((kp*(sp-z1)) - z2) * inv, clamped
         5'd4:    w = uw(OP_SUB,   JC_NONE,   STEP_CALC,  SRC_SP,   SRC_Z1,  DST_T);
         5'd5:    w = uw(OP_MUL,   JC_NONE,   STEP_CALC,  SRC_KP,   SRC_T,   DST_T);
         5'd6:    w = uw(OP_SUB,   JC_NONE,   STEP_CALC,  SRC_T,    SRC_Z2,  DST_T);
         5'd7:    w = uw(OP_MUL,   JC_NONE,   STEP_CALC,  SRC_T,    SRC_INV, DST_U);
         5'd8:    w = uw(OP_CLAMP, JC_NONE,   STEP_CALC,  SRC_U,    SRC_T,   DST_U);
         // observer update
         5'd9:    w = uw(OP_SUB,   JC_NONE,   STEP_CALC,  SRC_MEAS, SRC_Z1,  DST_ERR);
         5'd10:   w = uw(OP_MUL,   JC_NONE,   STEP_CALC,  SRC_B1,   SRC_ERR, DST_T);
         5'd11:   w = uw(OP_ADD,   JC_NONE,   STEP_CALC,  SRC_Z2,   SRC_T,   DST_D);
         5'd12:   w = uw(OP_MUL,   JC_NONE,   STEP_CALC,  SRC_B0,   SRC_U,   DST_T);
         5'd13:   w = uw(OP_ADD,   JC_NONE,   STEP_CALC,  SRC_D,    SRC_T,   DST_D);
         5'd14:   w = uw(OP_MUL,   JC_NONE,   STEP_CALC,  SRC_B2,   SRC_ERR, DST_T);
         5'd15:   w = uw(OP_MUL,   JC_NONE,   STEP_CALC,  SRC_T,    SRC_DT,  DST_T);
         5'd16:   w = uw(OP_ADD,   JC_NONE,   STEP_CALC,  SRC_Z2,   SRC_T,   DST_Z2);
         5'd17:   w = uw(OP_MUL,   JC_NONE,   STEP_CALC,  SRC_D,    SRC_DT,  DST_T);
         5'd18:   w = uw(OP_ADD,   JC_NONE,   STEP_CALC,  SRC_Z1,   SRC_T,   DST_Z1);
         5'd19:   w = uw(OP_DONE,  JC_NONE,   STEP_CALC,  SRC_T,    SRC_T,   DST_NONE);
         5'd20:   w = uw(OP_CLEAR, JC_ALWAYS, STEP_DONE,  SRC_T,    SRC_T,   DST_NONE);
         5'd21:   w = uw(OP_ZERO,  JC_NONE,   STEP_CALC,  SRC_T,    SRC_T,   DST_NONE);
         default: w = uw(OP_DONE,  JC_NONE,   STEP_CALC,  SRC_T,    SRC_T,   DST_NONE);
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ----- design/adrc_req_if.sv -----
// ----------------------------------------------------------------------------
// adrc_req_if
// request channel: one beat carries an update or a clear request
// ----------------------------------------------------------------------------
`default_nettype none

interface adrc_req_if;
   import adrc_pkg::*;

   logic     valid;
   logic     ready;
   logic     req_type;
   data_type setpoint;
   data_type measured;
   data_type time_step;

   modport source(output valid, req_type, setpoint, measured, time_step, input ready);
   modport sink(input valid, req_type, setpoint, measured, time_step, output ready);
endinterface

`default_nettype wire

// ----- design/adrc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// adrc_rsp_if
// response channel: one beat carries the clamped drive
// ----------------------------------------------------------------------------
`default_nettype none

interface adrc_rsp_if;
   import adrc_pkg::*;

   logic     valid;
   logic     ready;
   data_type drive;

   modport source(output valid, drive, input ready);
   modport sink(input valid, drive, output ready);
endinterface

`default_nettype wire

// ----- design/adrc_csr_if.sv -----
// ----------------------------------------------------------------------------
// adrc_csr_if
// register write channel: index and data per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface adrc_csr_if;
   import adrc_pkg::*;

   logic          valid;
   logic          ready;
   csr_index_type index;
   gain_type      data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/adrc_axis_regulator.sv -----
// ----------------------------------------------------------------------------
// adrc_axis_regulator: one-axis linear adrc with extended state observer
// update: seeds the observer on the first request, then runs seven multiplies
// through one 40x20 multiplier; its response waits while the last is untaken
// clear zeroes the state, a nonpositive step zeroes the drive; one request in
// flight, the next beat accepted once the response is issued
// reset clears estimate, disturbance, seed flag; registers take defaults
// ----------------------------------------------------------------------------
`default_nettype none

module adrc_axis_regulator (
   input wire logic clock,
   input wire logic reset,
   adrc_req_if.sink   req_chan,
   adrc_rsp_if.source rsp_chan,
   adrc_csr_if.sink   csr_chan
);
   import adrc_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   // control
   logic       state_ff, state_in;
   step_type   step_ff, step_in;
   logic [2:0] phase_ff, phase_in;
   logic       primed_ff, primed_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // configuration
   gain_type kp_ff, kp_in;
   gain_type b1_ff, b1_in;
   gain_type b2_ff, b2_in;
   gain_type b0_ff, b0_in;
   gain_type inv_ff, inv_in;
   gain_type lim_ff, lim_in;

   // state and working registers
   data_type z1_ff, z1_in;
   data_type z2_ff, z2_in;
   data_type u_ff, u_in;
   data_type err_ff, err_in;
   data_type t_ff, t_in;
   data_type d_ff, d_in;
   data_type drive_ff, drive_in;

   // latched request
   logic     clr_ff, clr_in;
   data_type sp_ff, sp_in;
   data_type meas_ff, meas_in;
   data_type dt_ff, dt_in;

   // multiplier
   logic [39:0] ma_ff, ma_in;
   logic [39:0] mb_ff, mb_in;
   logic        neg_ff, neg_in;
   logic [59:0] prod_ff, prod_in;
   logic [79:0] acc_ff, acc_in;

   ucode_type   word;
   data_type    opa, opb;
   logic signed [40:0] sum;
   data_type    sum_sat;
   data_type    clamp_val;
   data_type    lim_s;
   logic [39:0] opa_u, opb_u;
   logic [19:0] mul_half;
   logic [59:0] mul_out;
   logic [79:0] acc_rnd;
   logic [55:0] rnd_hi;
   logic [39:0] mag;
   data_type    mul_res;
   logic        wr_en;
   data_type    wr_data;
   logic        advance;
   logic        jump;
   logic        out_free;

   function automatic data_type operand(input logic [3:0] src);
      data_type v;
      case (src)
         SRC_SP:   v = sp_ff;
         SRC_MEAS: v = meas_ff;
         SRC_DT:   v = dt_ff;
         SRC_KP:   v = {1'b0, kp_ff};
         SRC_B1:   v = {1'b0, b1_ff};
         SRC_B2:   v = {1'b0, b2_ff};
         SRC_B0:   v = {1'b0, b0_ff};
         SRC_INV:  v = {1'b0, inv_ff};
         SRC_Z1:   v = z1_ff;
         SRC_Z2:   v = z2_ff;
         SRC_U:    v = u_ff;
         SRC_ERR:  v = err_ff;
         SRC_T:    v = t_ff;
         SRC_D:    v = d_ff;
         default:  v = '0;
      endcase
      return v;
   endfunction

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.drive = drive_ff;

   // datapath
   always_comb begin
      word = ucode_rom(step_ff);
      opa  = operand(word.src_a);
      opb  = operand(word.src_b);

      if (word.op == OP_SUB) begin
         sum = {opa[39], opa} - {opb[39], opb};
      end else begin
         sum = {opa[39], opa} + {opb[39], opb};
      end
      if (sum[40] != sum[39]) begin
         sum_sat = sum[40] ? 40'sh80_0000_0000 : 40'sh7F_FFFF_FFFF;
      end else begin
         sum_sat = sum[39:0];
      end

      lim_s = {1'b0, lim_ff};
      if (opa > lim_s) begin
         clamp_val = lim_s;
      end else if (opa < -lim_s) begin
         clamp_val = -lim_s;
      end else begin
         clamp_val = opa;
      end

      opa_u    = opa[39] ? (~opa + 40'd1) : opa;
      opb_u    = opb[39] ? (~opb + 40'd1) : opb;
      mul_half = (phase_ff == 3'd1) ? mb_ff[19:0] : mb_ff[39:20];
      mul_out  = ma_ff * mul_half;
      acc_rnd  = acc_ff + 80'd8388608;
      rnd_hi   = acc_rnd[79:24];
      mag      = (rnd_hi > 56'd549755813888) ? 40'h80_0000_0000 : rnd_hi[39:0];
      if (neg_ff) begin
         mul_res = -mag;
      end else begin
         mul_res = mag[39] ? 40'sh7F_FFFF_FFFF : mag;
      end

      case (word.cond)
         JC_CLEAR:  jump = clr_ff;
         JC_BADDT:  jump = dt_ff[39] || (dt_ff == '0);
         JC_PRIMED: jump = primed_ff;
         JC_ALWAYS: jump = 1'b1;
         default:   jump = 1'b0;
      endcase

      out_free = !rsp_valid_ff || rsp_chan.ready;
   end

   // sequencer and next state
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      phase_in     = phase_ff;
      primed_in    = primed_ff;
      rsp_valid_in = rsp_valid_ff;
      kp_in        = kp_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      b0_in        = b0_ff;
      inv_in       = inv_ff;
      lim_in       = lim_ff;
      z1_in        = z1_ff;
      z2_in        = z2_ff;
      u_in         = u_ff;
      err_in       = err_ff;
      t_in         = t_ff;
      d_in         = d_ff;
      drive_in     = drive_ff;
      clr_in       = clr_ff;
      sp_in        = sp_ff;
      meas_in      = meas_ff;
      dt_in        = dt_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      wr_en        = 1'b0;
      wr_data      = sum_sat;
      advance      = 1'b1;

      if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_TRACK_GAIN:     kp_in  = csr_chan.data;
            REG_OBSERVER_GAIN1: b1_in  = csr_chan.data;
            REG_OBSERVER_GAIN2: b2_in  = csr_chan.data;
            REG_PLANT_GAIN:     b0_in  = csr_chan.data;
            REG_INV_PLANT_GAIN: inv_in = csr_chan.data;
            REG_DRIVE_LIMIT:    lim_in = csr_chan.data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               clr_in   = req_chan.req_type;
               sp_in    = req_chan.setpoint;
               meas_in  = req_chan.measured;
               dt_in    = req_chan.time_step;
               step_in  = '0;
               phase_in = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            case (word.op)
               OP_NOP: ;
               OP_SEED: begin
                  z1_in     = meas_ff;
                  z2_in     = '0;
                  primed_in = 1'b1;
               end
               OP_ADD, OP_SUB: begin
                  wr_en   = 1'b1;
                  wr_data = sum_sat;
               end
               OP_MUL: begin
                  advance = 1'b0;
                  case (phase_ff)
                     3'd0: begin
                        ma_in    = opa_u;
                        mb_in    = opb_u;
                        neg_in   = opa[39] ^ opb[39];
                        phase_in = 3'd1;
                     end
                     3'd1: begin
                        prod_in  = mul_out;
                        phase_in = 3'd2;
                     end
                     3'd2: begin
                        acc_in   = {20'd0, prod_ff};
                        prod_in  = mul_out;
                        phase_in = 3'd3;
                     end
                     3'd3: begin
                        acc_in   = acc_ff + {prod_ff, 20'd0};
                        phase_in = 3'd4;
                     end
                     default: begin
                        wr_en    = 1'b1;
                        wr_data  = mul_res;
                        phase_in = 3'd0;
                        advance  = 1'b1;
                     end
                  endcase
               end
               OP_CLAMP: begin
                  wr_en   = 1'b1;
                  wr_data = clamp_val;
               end
               OP_CLEAR: begin
                  z1_in     = '0;
                  z2_in     = '0;
                  primed_in = 1'b0;
                  u_in      = '0;
               end
               OP_ZERO: begin
                  u_in = '0;
               end
               OP_DONE: begin
                  advance = 1'b0;
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     drive_in     = u_ff;
                     state_in     = ST_IDLE;
                  end
               end
               default: ;
            endcase

            if (wr_en) begin
               case (word.dst)
                  DST_T:   t_in   = wr_data;
                  DST_U:   u_in   = wr_data;
                  DST_ERR: err_in = wr_data;
                  DST_D:   d_in   = wr_data;
                  DST_Z1:  z1_in  = wr_data;
                  DST_Z2:  z2_in  = wr_data;
                  default: ;
               endcase
            end

            if (advance) begin
               step_in = jump ? word.target : step_ff + 5'd1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         phase_ff     <= '0;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         kp_ff        <= TRACK_GAIN_RESET;
         b1_ff        <= OBSERVER_GAIN1_RESET;
         b2_ff        <= OBSERVER_GAIN2_RESET;
         b0_ff        <= PLANT_GAIN_RESET;
         inv_ff       <= INV_PLANT_GAIN_RESET;
         lim_ff       <= DRIVE_LIMIT_RESET;
         z1_ff        <= '0;
         z2_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
         kp_ff        <= kp_in;
         b1_ff        <= b1_in;
         b2_ff        <= b2_in;
         b0_ff        <= b0_in;
         inv_ff       <= inv_in;
         lim_ff       <= lim_in;
         z1_ff        <= z1_in;
         z2_ff        <= z2_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff     <= u_in;
      err_ff   <= err_in;
      t_ff     <= t_in;
      d_ff     <= d_in;
      drive_ff <= drive_in;
      clr_ff   <= clr_in;
      sp_ff    <= sp_in;
      meas_ff  <= meas_in;
      dt_ff    <= dt_in;
      ma_ff    <= ma_in;
      mb_ff    <= mb_in;
      neg_ff   <= neg_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
   end

endmodule

`default_nettype wire
